// ===== hdl/twm_pkg.sv =====
package twm_pkg;

  // Command codes carried in the command field of a request.
  localparam logic [3:0] CMD_FWD    = 4'd0;
  localparam logic [3:0] CMD_BACK   = 4'd1;
  localparam logic [3:0] CMD_LEFT   = 4'd2;
  localparam logic [3:0] CMD_RIGHT  = 4'd3;
  localparam logic [3:0] CMD_STOP   = 4'd4;
  localparam logic [3:0] CMD_SPEED  = 4'd5;
  localparam logic [3:0] CMD_REPORT = 4'd6;
  localparam logic [3:0] CMD_LEDGE  = 4'd7;
  localparam logic [3:0] CMD_REDGE  = 4'd8;
  localparam logic [3:0] CMD_TICK   = 4'd9;

  // Wheel count direction.
  localparam logic [1:0] DIR_NONE = 2'd0;
  localparam logic [1:0] DIR_UP   = 2'd1;
  localparam logic [1:0] DIR_DOWN = 2'd3;

  // Bridge pin drive codes.
  localparam logic [1:0] DRV_OFF = 2'd0;
  localparam logic [1:0] DRV_FWD = 2'd1;
  localparam logic [1:0] DRV_REV = 2'd2;

  // Result event codes.
  localparam logic [1:0] EV_NONE   = 2'd0;
  localparam logic [1:0] EV_DONE   = 2'd1;
  localparam logic [1:0] EV_STALL  = 2'd2;
  localparam logic [1:0] EV_REPORT = 2'd3;

  // Configuration register indexes.
  localparam logic [1:0] CFG_CPC    = 2'd0;
  localparam logic [1:0] CFG_RADIUS = 2'd1;
  localparam logic [1:0] CFG_PERIOD = 2'd2;
  localparam logic [1:0] CFG_THRESH = 2'd3;

  localparam logic [15:0] CPC_RST    = 16'd1229;
  localparam logic [6:0]  RADIUS_RST = 7'd12;
  localparam logic [6:0]  PERIOD_RST = 7'd50;
  localparam logic [9:0]  THRESH_RST = 10'd5;
  localparam logic [3:0]  SPEED_RST  = 4'd5;

  localparam logic [3:0]  SPEED_MIN  = 4'd1;
  localparam logic [3:0]  SPEED_MAX  = 4'd10;
  localparam logic [15:0] AMOUNT_MIN = 16'd2;

  typedef enum logic [2:0] {
    S_IDLE,
    S_EXEC,
    S_MUL,
    S_AIM,
    S_STALL,
    S_OUT
  } state_t;

  typedef struct packed {
    logic load_in;
    logic exec;
    logic mul;
    logic aim;
    logic stall;
    logic load_out;
  } dp_cmd_t;

  typedef struct packed {
    logic bounded_move;
    logic stall_check;
    logic out_free;
  } dp_sts_t;

endpackage

// ===== hdl/twm_if.sv =====
interface twm_in_if;
  logic        valid;
  logic        ready;
  logic [3:0]  command;
  logic [3:0]  speed_level;
  logic [15:0] amount;

  modport source (output valid, command, speed_level, amount, input ready);
  modport sink   (input valid, command, speed_level, amount, output ready);
endinterface

interface twm_out_if;
  logic               valid;
  logic               ready;
  logic [1:0]         left_drive;
  logic [1:0]         right_drive;
  logic               pwm_enabled;
  logic [7:0]         duty;
  logic [1:0]         event_res;
  logic               stall_left;
  logic               stall_right;
  logic signed [31:0] left_count;
  logic signed [31:0] right_count;

  modport source (output valid, left_drive, right_drive, pwm_enabled, duty, event_res,
                  stall_left, stall_right, left_count, right_count, input ready);
  modport sink   (input valid, left_drive, right_drive, pwm_enabled, duty, event_res,
                  stall_left, stall_right, left_count, right_count, output ready);
endinterface

// ===== hdl/twm_ctrl.sv =====
module twm_ctrl
  import twm_pkg::*;
(
  input  logic    clk,
  input  logic    rst_n,
  input  logic    in_valid,
  output logic    in_ready,
  output dp_cmd_t cmd,
  input  dp_sts_t sts
);

  state_t state_r;
  state_t state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) state_nxt = S_EXEC;
      end
      S_EXEC: begin
        if (sts.bounded_move) begin
          state_nxt = S_MUL;
        end else if (sts.stall_check) begin
          state_nxt = S_STALL;
        end else begin
          state_nxt = S_OUT;
        end
      end
      S_MUL:   state_nxt = S_AIM;
      S_AIM:   state_nxt = S_OUT;
      S_STALL: state_nxt = S_OUT;
      S_OUT: begin
        if (sts.out_free) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    in_ready     = 1'b0;
    cmd          = '0;
    unique case (state_r)
      S_IDLE: begin
        in_ready    = 1'b1;
        cmd.load_in = in_valid;
      end
      S_EXEC:  cmd.exec     = 1'b1;
      S_MUL:   cmd.mul      = 1'b1;
      S_AIM:   cmd.aim      = 1'b1;
      S_STALL: cmd.stall    = 1'b1;
      S_OUT:   cmd.load_out = sts.out_free;
      default: cmd          = '0;
    endcase
  end

endmodule

// ===== hdl/twm_dp.sv =====
module twm_dp
  import twm_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  dp_cmd_t            cmd,
  output dp_sts_t            sts,
  input  logic               cfg_we,
  input  logic [1:0]         cfg_index,
  input  logic [15:0]        cfg_wdata,
  input  logic [3:0]         in_command,
  input  logic [3:0]         in_speed_level,
  input  logic [15:0]        in_amount,
  input  logic               out_ready,
  output logic               out_valid,
  output logic [1:0]         out_left_drive,
  output logic [1:0]         out_right_drive,
  output logic               out_pwm_enabled,
  output logic [7:0]         out_duty,
  output logic [1:0]         out_event_res,
  output logic               out_stall_left,
  output logic               out_stall_right,
  output logic signed [31:0] out_left_count,
  output logic signed [31:0] out_right_count
);

  // Configuration registers.
  logic [15:0] cpc_r;
  logic [6:0]  radius_r;
  logic [6:0]  period_r;
  logic [9:0]  thresh_r;

  // Latched request.
  logic [3:0]  command_r;
  logic [3:0]  level_r;
  logic [15:0] amount_r;

  // Controller state.
  logic [31:0] lpos_r, lpos_nxt;
  logic [31:0] rpos_r, rpos_nxt;
  logic [1:0]  ldir_r, ldir_nxt;
  logic [1:0]  rdir_r, rdir_nxt;
  logic [31:0] ltgt_r, ltgt_nxt;
  logic [31:0] rtgt_r, rtgt_nxt;
  logic        free_r, free_nxt;
  logic [3:0]  speed_r, speed_nxt;
  logic        pwm_r, pwm_nxt;
  logic [1:0]  lpins_r, lpins_nxt;
  logic [1:0]  rpins_r, rpins_nxt;
  logic [6:0]  phase_r, phase_nxt;
  logic [31:0] lsnap_r, lsnap_nxt;
  logic [31:0] rsnap_r, rsnap_nxt;

  // Working registers.
  logic [31:0] prod1_r;
  logic [38:0] prod2_r;
  logic [31:0] ldiff_r, ldiff_nxt;
  logic [31:0] rdiff_r, rdiff_nxt;
  logic [1:0]  ev_r, ev_nxt;
  logic        sl_r, sl_nxt;
  logic        sr_r, sr_nxt;

  logic        out_valid_r;

  logic        is_turn;
  logic        is_move;
  logic [31:0] lstep;
  logic [31:0] rstep;
  logic [6:0]  phase_inc;
  logic [6:0]  phase_new;
  logic [31:0] cnt;
  logic [31:0] lmag;
  logic [31:0] rmag;
  logic [31:0] thresh_ext;
  logic [7:0]  duty_w;

  assign is_turn   = (command_r == CMD_LEFT) || (command_r == CMD_RIGHT);
  assign is_move   = is_turn || (command_r == CMD_FWD) || (command_r == CMD_BACK);
  assign phase_inc = phase_r + 7'd1;
  assign phase_new = (phase_inc >= period_r) ? 7'd0 : phase_inc;

  assign sts.bounded_move = is_move && (amount_r >= AMOUNT_MIN);
  assign sts.stall_check  = (command_r == CMD_TICK) && (phase_new == 7'd0);
  assign sts.out_free     = !out_valid_r || out_ready;

  assign lstep = (ldir_r == DIR_UP)   ? lpos_r + 32'd1 :
                 (ldir_r == DIR_DOWN) ? lpos_r - 32'd1 : lpos_r;
  assign rstep = (rdir_r == DIR_UP)   ? rpos_r + 32'd1 :
                 (rdir_r == DIR_DOWN) ? rpos_r - 32'd1 : rpos_r;

  // The scaled product is shifted down by twelve bits; only 27 bits survive.
  assign cnt = {5'd0, prod2_r[38:12]};

  // Negating the most negative difference leaves it large, as intended.
  assign lmag       = ldiff_r[31] ? (32'd0 - ldiff_r) : ldiff_r;
  assign rmag       = rdiff_r[31] ? (32'd0 - rdiff_r) : rdiff_r;
  assign thresh_ext = {22'd0, thresh_r};

  assign duty_w = 8'(speed_r) * 8'd15 + 8'd100;

  always_comb begin
    lpos_nxt  = lpos_r;
    rpos_nxt  = rpos_r;
    ldir_nxt  = ldir_r;
    rdir_nxt  = rdir_r;
    ltgt_nxt  = ltgt_r;
    rtgt_nxt  = rtgt_r;
    free_nxt  = free_r;
    speed_nxt = speed_r;
    pwm_nxt   = pwm_r;
    lpins_nxt = lpins_r;
    rpins_nxt = rpins_r;
    phase_nxt = phase_r;
    lsnap_nxt = lsnap_r;
    rsnap_nxt = rsnap_r;
    ldiff_nxt = ldiff_r;
    rdiff_nxt = rdiff_r;
    ev_nxt    = ev_r;
    sl_nxt    = sl_r;
    sr_nxt    = sr_r;

    if (cmd.load_in) begin
      ev_nxt = EV_NONE;
      sl_nxt = 1'b0;
      sr_nxt = 1'b0;
    end

    if (cmd.exec) begin
      unique case (command_r) inside
        CMD_FWD, CMD_BACK, CMD_LEFT, CMD_RIGHT, CMD_SPEED: begin
          if (level_r >= SPEED_MIN && level_r <= SPEED_MAX) speed_nxt = level_r;
          pwm_nxt = 1'b1;
          if (is_move) free_nxt = !sts.bounded_move;
          unique case (command_r) inside
            CMD_FWD: begin
              ldir_nxt  = DIR_UP;
              rdir_nxt  = DIR_UP;
              lpins_nxt = DRV_FWD;
              rpins_nxt = DRV_FWD;
            end
            CMD_BACK: begin
              ldir_nxt  = DIR_DOWN;
              rdir_nxt  = DIR_DOWN;
              lpins_nxt = DRV_REV;
              rpins_nxt = DRV_REV;
            end
            CMD_LEFT: begin
              ldir_nxt  = DIR_DOWN;
              rdir_nxt  = DIR_UP;
              lpins_nxt = DRV_FWD;
              rpins_nxt = DRV_REV;
            end
            CMD_RIGHT: begin
              ldir_nxt  = DIR_UP;
              rdir_nxt  = DIR_DOWN;
              lpins_nxt = DRV_REV;
              rpins_nxt = DRV_FWD;
            end
            default: ;
          endcase
        end
        CMD_STOP: begin
          ldir_nxt  = DIR_NONE;
          rdir_nxt  = DIR_NONE;
          lpins_nxt = DRV_OFF;
          rpins_nxt = DRV_OFF;
          pwm_nxt   = 1'b0;
        end
        CMD_REPORT: ev_nxt = EV_REPORT;
        CMD_LEDGE, CMD_REDGE: begin
          if (command_r == CMD_LEDGE) begin
            lpos_nxt = lstep;
          end else begin
            rpos_nxt = rstep;
          end
          if (!free_r && ((command_r == CMD_LEDGE) ? (ltgt_r == lstep)
                                                   : (rtgt_r == rstep))) begin
            ldir_nxt  = DIR_NONE;
            rdir_nxt  = DIR_NONE;
            lpins_nxt = DRV_OFF;
            rpins_nxt = DRV_OFF;
            pwm_nxt   = 1'b0;
            ev_nxt    = EV_DONE;
          end
        end
        CMD_TICK: begin
          phase_nxt = phase_new;
          if (sts.stall_check) begin
            ldiff_nxt = lsnap_r - lpos_r;
            rdiff_nxt = rsnap_r - rpos_r;
            lsnap_nxt = lpos_r;
            rsnap_nxt = rpos_r;
          end
        end
        default: ;
      endcase
    end

    if (cmd.aim) begin
      ltgt_nxt = (ldir_r == DIR_UP) ? lpos_r + cnt : lpos_r - cnt;
      rtgt_nxt = (rdir_r == DIR_UP) ? rpos_r + cnt : rpos_r - cnt;
    end

    if (cmd.stall) begin
      sl_nxt = (ldir_r != DIR_NONE) && (lmag < thresh_ext);
      sr_nxt = (rdir_r != DIR_NONE) && (rmag < thresh_ext);
      ev_nxt = (sl_nxt || sr_nxt) ? EV_STALL : EV_NONE;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cpc_r       <= CPC_RST;
      radius_r    <= RADIUS_RST;
      period_r    <= PERIOD_RST;
      thresh_r    <= THRESH_RST;
      lpos_r      <= '0;
      rpos_r      <= '0;
      ldir_r      <= DIR_NONE;
      rdir_r      <= DIR_NONE;
      ltgt_r      <= '0;
      rtgt_r      <= '0;
      free_r      <= 1'b1;
      speed_r     <= SPEED_RST;
      pwm_r       <= 1'b0;
      lpins_r     <= DRV_OFF;
      rpins_r     <= DRV_OFF;
      phase_r     <= '0;
      lsnap_r     <= '0;
      rsnap_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          CFG_CPC:    cpc_r    <= cfg_wdata;
          CFG_RADIUS: radius_r <= cfg_wdata[6:0];
          CFG_PERIOD: period_r <= cfg_wdata[6:0];
          CFG_THRESH: thresh_r <= cfg_wdata[9:0];
          default: ;
        endcase
      end
      lpos_r  <= lpos_nxt;
      rpos_r  <= rpos_nxt;
      ldir_r  <= ldir_nxt;
      rdir_r  <= rdir_nxt;
      ltgt_r  <= ltgt_nxt;
      rtgt_r  <= rtgt_nxt;
      free_r  <= free_nxt;
      speed_r <= speed_nxt;
      pwm_r   <= pwm_nxt;
      lpins_r <= lpins_nxt;
      rpins_r <= rpins_nxt;
      phase_r <= phase_nxt;
      lsnap_r <= lsnap_nxt;
      rsnap_r <= rsnap_nxt;
      if (cmd.load_out) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      command_r <= in_command;
      level_r   <= in_speed_level;
      amount_r  <= in_amount;
    end
    if (cmd.exec) prod1_r <= 32'(amount_r) * 32'(cpc_r);
    if (cmd.mul) prod2_r <= is_turn ? 39'(prod1_r) * 39'(radius_r) : {7'd0, prod1_r};
    ldiff_r <= ldiff_nxt;
    rdiff_r <= rdiff_nxt;
    ev_r    <= ev_nxt;
    sl_r    <= sl_nxt;
    sr_r    <= sr_nxt;
    if (cmd.load_out) begin
      out_left_drive  <= lpins_r;
      out_right_drive <= rpins_r;
      out_pwm_enabled <= pwm_r;
      out_duty        <= duty_w;
      out_event_res   <= ev_r;
      out_stall_left  <= sl_r;
      out_stall_right <= sr_r;
      out_left_count  <= $signed(lpos_r);
      out_right_count <= $signed(rpos_r);
    end
  end

  assign out_valid = out_valid_r;

endmodule

// ===== hdl/two_wheel_encoder_move_controller.sv =====
// Steps: an accepted request runs an execute step, then an output step; a stall-check
// tick adds a stall step, and a bounded move a multiply step (radius, turns only) and a
// target add. One request is worked on at a time. A waiting result sits in the output
// register and does not block the next request; that request then holds in the output step.
// Reset: rst_n is synchronous and active low; it clears counts, targets, snapshots and the
// tick phase, stops both wheels and reloads the configuration registers with their defaults.
module two_wheel_encoder_move_controller
  import twm_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  twm_in_if.sink      in_ch,
  twm_out_if.source   out_ch,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_wdata
);

  dp_cmd_t dp_cmd;
  dp_sts_t dp_sts;

  twm_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ch.ready),
    .cmd      (dp_cmd),
    .sts      (dp_sts)
  );

  twm_dp u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (dp_cmd),
    .sts             (dp_sts),
    .cfg_we          (cfg_we),
    .cfg_index       (cfg_index),
    .cfg_wdata       (cfg_wdata),
    .in_command      (in_ch.command),
    .in_speed_level  (in_ch.speed_level),
    .in_amount       (in_ch.amount),
    .out_ready       (out_ch.ready),
    .out_valid       (out_ch.valid),
    .out_left_drive  (out_ch.left_drive),
    .out_right_drive (out_ch.right_drive),
    .out_pwm_enabled (out_ch.pwm_enabled),
    .out_duty        (out_ch.duty),
    .out_event_res   (out_ch.event_res),
    .out_stall_left  (out_ch.stall_left),
    .out_stall_right (out_ch.stall_right),
    .out_left_count  (out_ch.left_count),
    .out_right_count (out_ch.right_count)
  );

endmodule

// ===== hdl/twm_checker.sv =====
module twm_checker
  import twm_pkg::*;
(
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [1:0]  left_drive,
  input logic [1:0]  right_drive,
  input logic        pwm_enabled,
  input logic [1:0]  event_res,
  input logic        stall_left,
  input logic        stall_right,
  input logic [31:0] left_count
);

  // A stalled result must hold until it is taken.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(event_res) && $stable(left_count))
    else $error("result changed while stalled");

  a_flags_only_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (event_res != EV_STALL) |-> !stall_left && !stall_right)
    else $error("stall flag without stall event");

  a_stall_has_flag: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (event_res == EV_STALL) |-> stall_left || stall_right)
    else $error("stall event without a flagged wheel");

  // Stopping always clears the bridge pins together with the PWM enable.
  a_off_pins_low: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !pwm_enabled |-> (left_drive == DRV_OFF) && (right_drive == DRV_OFF))
    else $error("bridge driven with PWM off");

  // One request is worked on at a time.
  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("request accepted while busy");

endmodule

bind two_wheel_encoder_move_controller twm_checker u_twm_checker (
  .clk         (clk),
  .rst_n       (rst_n),
  .in_valid    (in_ch.valid),
  .in_ready    (in_ch.ready),
  .out_valid   (out_ch.valid),
  .out_ready   (out_ch.ready),
  .left_drive  (out_ch.left_drive),
  .right_drive (out_ch.right_drive),
  .pwm_enabled (out_ch.pwm_enabled),
  .event_res   (out_ch.event_res),
  .stall_left  (out_ch.stall_left),
  .stall_right (out_ch.stall_right),
  .left_count  (out_ch.left_count)
);

// ===== tb/sv/two_wheel_encoder_move_controller_test.sv =====
module two_wheel_encoder_move_controller_test
  import twm_pkg::*;
();

  timeunit 1ns;
  timeprecision 1ps;

  localparam int IDLE_LIMIT = 5000;
  localparam int LONG_HOLD = 300;
  localparam int SETTLE_CYCLES = 6;
  localparam logic [3:0] CMD_UNUSED_LO = 4'd10;
  localparam logic [3:0] CMD_UNUSED_HI = 4'd15;

  typedef struct packed {
    logic [3:0]  command;
    logic [3:0]  speed_level;
    logic [15:0] amount;
  } wheel_req_t;

  typedef struct packed {
    logic [1:0]  left_drive;
    logic [1:0]  right_drive;
    logic        pwm_enabled;
    logic [7:0]  duty;
    logic [1:0]  event_res;
    logic        stall_left;
    logic        stall_right;
    logic [31:0] left_count;
    logic [31:0] right_count;
  } wheel_status_t;

  logic        clk;
  logic        rst_n;
  logic        cfg_we;
  logic [1:0]  cfg_index;
  logic [15:0] cfg_wdata;

  twm_in_if  in_ch();
  twm_out_if out_ch();

  two_wheel_encoder_move_controller i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  // Configuration as the block should hold it.
  logic [15:0] cpc_q8;
  logic [6:0]  radius_cm;
  logic [6:0]  period_ticks;
  logic [9:0]  stall_min;

  // Predicted controller state.
  logic [31:0] left_pos, right_pos;
  logic [31:0] left_tgt, right_tgt;
  logic [31:0] left_snap, right_snap;
  logic [1:0]  left_dir, right_dir;
  logic [1:0]  left_drv, right_drv;
  logic        free_run;
  logic        pwm_on;
  logic [3:0]  speed_set;
  logic [6:0]  tick_ph;

  wheel_req_t    pending_reqs[$];
  wheel_status_t expected_status[$];
  wheel_req_t    offered_req;

  int          reqs_queued;
  int          reqs_accepted;
  int          results_checked;
  int          mismatch_count;
  int          done_events;
  int          stall_events;
  int          report_events;
  int          settings_used;
  int          send_gap;
  int          ready_gap;
  int          hold_left;
  bit          long_hold_done;
  int          quiet_cycles;
  logic [31:0] cycle_count = '0;

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  function automatic int pick_gap(input bit calm);
    int r;
    if (calm) return 0;
    r = $urandom_range(99, 0);
    if (r < 45) return 0;
    if (r < 85) return $urandom_range(3, 1);
    if (r < 97) return $urandom_range(12, 4);
    return $urandom_range(60, 20);
  endfunction

  task automatic reset_model();
    cpc_q8 = CPC_RST;
    radius_cm = RADIUS_RST;
    period_ticks = PERIOD_RST;
    stall_min = THRESH_RST;
    left_pos = '0;
    right_pos = '0;
    left_tgt = '0;
    right_tgt = '0;
    left_snap = '0;
    right_snap = '0;
    left_dir = DIR_NONE;
    right_dir = DIR_NONE;
    left_drv = DRV_OFF;
    right_drv = DRV_OFF;
    free_run = 1'b1;
    pwm_on = 1'b0;
    speed_set = SPEED_RST;
    tick_ph = '0;
  endtask

  task automatic halt_wheels();
    left_dir = DIR_NONE;
    right_dir = DIR_NONE;
    left_drv = DRV_OFF;
    right_drv = DRV_OFF;
    pwm_on = 1'b0;
  endtask

  task automatic take_speed(input logic [3:0] level);
    if (level >= SPEED_MIN && level <= SPEED_MAX) speed_set = level;
    pwm_on = 1'b1;
  endtask

  function automatic logic [31:0] wheel_step(input logic [31:0] pos, input logic [1:0] dir);
    if (dir == DIR_UP) return pos + 32'd1;
    if (dir == DIR_DOWN) return pos - 32'd1;
    return pos;
  endfunction

  function automatic logic [31:0] wheel_aim(input logic [31:0] pos, input logic [1:0] dir,
                                            input logic [31:0] span);
    return (dir == DIR_UP) ? pos + span : pos - span;
  endfunction

  // The most negative difference has no positive magnitude and stays large.
  function automatic bit is_stalled(input logic [31:0] snap, input logic [31:0] pos);
    logic [31:0] d;
    logic [31:0] mag;
    d = snap - pos;
    mag = d[31] ? -d : d;
    return mag < {22'd0, stall_min};
  endfunction

  task automatic begin_move(input wheel_req_t r, input bit turn, input logic [1:0] ldir,
                            input logic [1:0] rdir, input logic [1:0] ldrv,
                            input logic [1:0] rdrv);
    logic [63:0] prod;
    take_speed(r.speed_level);
    if (r.amount >= AMOUNT_MIN) begin
      prod = 64'(r.amount) * 64'(cpc_q8);
      if (turn) prod = prod * 64'(radius_cm);
      free_run = 1'b0;
      right_tgt = wheel_aim(right_pos, rdir, prod[43:12]);
      left_tgt = wheel_aim(left_pos, ldir, prod[43:12]);
    end else begin
      free_run = 1'b1;
    end
    left_dir = ldir;
    right_dir = rdir;
    left_drv = ldrv;
    right_drv = rdrv;
  endtask

  task automatic advance_model(input wheel_req_t r);
    wheel_status_t s;
    logic [1:0]    ev;
    logic          sl;
    logic          sr;
    ev = EV_NONE;
    sl = 1'b0;
    sr = 1'b0;
    case (r.command)
      CMD_FWD:    begin_move(r, 1'b0, DIR_UP, DIR_UP, DRV_FWD, DRV_FWD);
      CMD_BACK:   begin_move(r, 1'b0, DIR_DOWN, DIR_DOWN, DRV_REV, DRV_REV);
      CMD_LEFT:   begin_move(r, 1'b1, DIR_DOWN, DIR_UP, DRV_FWD, DRV_REV);
      CMD_RIGHT:  begin_move(r, 1'b1, DIR_UP, DIR_DOWN, DRV_REV, DRV_FWD);
      CMD_STOP:   halt_wheels();
      CMD_SPEED:  take_speed(r.speed_level);
      CMD_REPORT: ev = EV_REPORT;
      CMD_LEDGE: begin
        left_pos = wheel_step(left_pos, left_dir);
        if (!free_run && left_tgt == left_pos) begin
          halt_wheels();
          ev = EV_DONE;
        end
      end
      CMD_REDGE: begin
        right_pos = wheel_step(right_pos, right_dir);
        if (!free_run && right_tgt == right_pos) begin
          halt_wheels();
          ev = EV_DONE;
        end
      end
      CMD_TICK: begin
        tick_ph = tick_ph + 7'd1;
        if (tick_ph >= period_ticks) tick_ph = 7'd0;
        if (tick_ph == 7'd0) begin
          sl = left_dir != DIR_NONE && is_stalled(left_snap, left_pos);
          sr = right_dir != DIR_NONE && is_stalled(right_snap, right_pos);
          if (sl || sr) ev = EV_STALL;
          left_snap = left_pos;
          right_snap = right_pos;
        end
      end
      default: ;
    endcase
    if (ev == EV_DONE) done_events++;
    if (ev == EV_STALL) stall_events++;
    if (ev == EV_REPORT) report_events++;
    s.left_drive = left_drv;
    s.right_drive = right_drv;
    s.pwm_enabled = pwm_on;
    s.duty = 8'(speed_set) * 8'd15 + 8'd100;
    s.event_res = ev;
    s.stall_left = sl;
    s.stall_right = sr;
    s.left_count = left_pos;
    s.right_count = right_pos;
    expected_status.push_back(s);
  endtask

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    mismatch_count++;
    if (mismatch_count <= 40)
      $display("[%0t] result %0d: %s is %0h, expected %0h", $time, results_checked, what,
               got, want);
  endtask

  task automatic check_status();
    wheel_status_t want;
    results_checked++;
    if (expected_status.size() == 0) begin
      report_mismatch("result without a pending request", 32'd0, 32'd0);
      return;
    end
    want = expected_status.pop_front();
    if (out_ch.left_drive !== want.left_drive)
      report_mismatch("left_drive", 32'(out_ch.left_drive), 32'(want.left_drive));
    if (out_ch.right_drive !== want.right_drive)
      report_mismatch("right_drive", 32'(out_ch.right_drive), 32'(want.right_drive));
    if (out_ch.pwm_enabled !== want.pwm_enabled)
      report_mismatch("pwm_enabled", 32'(out_ch.pwm_enabled), 32'(want.pwm_enabled));
    if (out_ch.duty !== want.duty)
      report_mismatch("duty", 32'(out_ch.duty), 32'(want.duty));
    if (out_ch.event_res !== want.event_res)
      report_mismatch("event_res", 32'(out_ch.event_res), 32'(want.event_res));
    if (out_ch.stall_left !== want.stall_left)
      report_mismatch("stall_left", 32'(out_ch.stall_left), 32'(want.stall_left));
    if (out_ch.stall_right !== want.stall_right)
      report_mismatch("stall_right", 32'(out_ch.stall_right), 32'(want.stall_right));
    if (out_ch.left_count !== want.left_count)
      report_mismatch("left_count", out_ch.left_count, want.left_count);
    if (out_ch.right_count !== want.right_count)
      report_mismatch("right_count", out_ch.right_count, want.right_count);
  endtask

  always @(posedge clk) begin : request_driver
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
      send_gap = 0;
    end else begin
      if (in_ch.valid && in_ch.ready) begin
        advance_model(offered_req);
        reqs_accepted++;
      end
      if (in_ch.valid && !in_ch.ready) begin
        // Hold the offered request until the block takes it.
      end else if (send_gap != 0) begin
        in_ch.valid <= 1'b0;
        send_gap = send_gap - 1;
      end else if (pending_reqs.size() != 0) begin
        offered_req = pending_reqs.pop_front();
        in_ch.valid <= 1'b1;
        in_ch.command <= offered_req.command;
        in_ch.speed_level <= offered_req.speed_level;
        in_ch.amount <= offered_req.amount;
        send_gap = pick_gap(cycle_count[10:9] == 2'd0);
      end else begin
        in_ch.valid <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin : result_monitor
    int g;
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
      ready_gap = 0;
      hold_left = 0;
    end else begin
      g = ready_gap;
      if (out_ch.valid && out_ch.ready) begin
        check_status();
        g = pick_gap(cycle_count[9:8] == 2'd2);
      end
      ready_gap = g;
      if (hold_left != 0) begin
        out_ch.ready <= 1'b0;
        hold_left = hold_left - 1;
      end else if (!long_hold_done && results_checked > 100 && pending_reqs.size() > 40) begin
        // Keep results backed up long enough that the block has to refuse requests.
        long_hold_done = 1'b1;
        hold_left = LONG_HOLD;
        out_ch.ready <= 1'b0;
      end else if (g != 0) begin
        out_ch.ready <= 1'b0;
        ready_gap = g - 1;
      end else begin
        out_ch.ready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin : watchdog
    cycle_count <= cycle_count + 32'd1;
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) || cfg_we) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == IDLE_LIMIT) begin
      $display("Timeout: no request or result moved for %0d cycles", IDLE_LIMIT);
      $display("Regression FAIL");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic queue_req(input logic [3:0] cmd, input logic [3:0] level,
                           input logic [15:0] amt);
    wheel_req_t r;
    r.command = cmd;
    r.speed_level = level;
    r.amount = amt;
    pending_reqs.push_back(r);
    reqs_queued++;
  endtask

  // A move followed by a run of encoder edges, mostly on one wheel, sized from the move's count.
  task automatic queue_move_sequence();
    logic [3:0]  cmd;
    logic [15:0] amt;
    logic [63:0] span;
    int          edges;
    int          pick;
    bit          favor_left;
    cmd = 4'($urandom_range(3, 0));
    amt = ($urandom_range(9, 0) == 0) ? 16'($urandom_range(1, 0)) : 16'($urandom_range(24, 2));
    queue_req(cmd, 4'($urandom), amt);
    span = 64'(amt) * 64'(cpc_q8);
    if (cmd == CMD_LEFT || cmd == CMD_RIGHT) span = span * 64'(radius_cm);
    span = span >> 12;
    edges = (span > 64'd30) ? 30 : int'(span);
    edges = edges + edges / 3 + $urandom_range(4, 1);
    favor_left = 1'($urandom_range(1, 0));
    repeat (edges) begin
      pick = $urandom_range(99, 0);
      if (pick < 7) queue_req(CMD_TICK, 4'($urandom), 16'($urandom));
      else if (pick < 9) queue_req(CMD_REPORT, 4'($urandom), 16'($urandom));
      else if (pick < 11) queue_req(CMD_STOP, 4'($urandom), 16'($urandom));
      else if ((pick < 82) == favor_left) queue_req(CMD_LEDGE, 4'($urandom), 16'($urandom));
      else queue_req(CMD_REDGE, 4'($urandom), 16'($urandom));
    end
  endtask

  task automatic queue_random(input int n);
    int stop_at;
    stop_at = reqs_queued + n;
    while (reqs_queued < stop_at) begin
      if ($urandom_range(9, 0) < 7) queue_move_sequence();
      else queue_req(4'($urandom), 4'($urandom), 16'($urandom));
    end
  endtask

  task automatic drain();
    while (reqs_accepted != reqs_queued || expected_status.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_cfg(input logic [1:0] idx, input logic [15:0] val);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    case (idx)
      CFG_CPC:    cpc_q8 = val;
      CFG_RADIUS: radius_cm = val[6:0];
      CFG_PERIOD: period_ticks = val[6:0];
      CFG_THRESH: stall_min = val[9:0];
      default: ;
    endcase
  endtask

  task automatic set_config(input logic [15:0] cpc, input logic [6:0] radius,
                            input logic [6:0] period, input logic [9:0] thresh);
    write_cfg(CFG_CPC, cpc);
    write_cfg(CFG_RADIUS, 16'(radius));
    write_cfg(CFG_PERIOD, 16'(period));
    write_cfg(CFG_THRESH, 16'(thresh));
    @(posedge clk);
    cfg_we <= 1'b0;
    settings_used++;
  endtask

  initial begin : stimulus
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_index = CFG_CPC;
    cfg_wdata = '0;
    in_ch.valid = 1'b0;
    in_ch.command = CMD_REPORT;
    in_ch.speed_level = '0;
    in_ch.amount = '0;
    out_ch.ready = 1'b0;
    reset_model();
    settings_used = 1;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // Speed levels outside 1..10 keep the old setting but still enable PWM.
    queue_req(CMD_REPORT, 4'd0, 16'd0);
    queue_req(CMD_SPEED, 4'd0, 16'd0);
    queue_req(CMD_SPEED, 4'd15, 16'hFFFF);
    queue_req(CMD_SPEED, 4'd11, 16'd0);
    queue_req(CMD_SPEED, SPEED_MIN, 16'd0);
    queue_req(CMD_SPEED, SPEED_MAX, 16'd0);
    queue_req(CMD_STOP, 4'd0, 16'd0);
    // Amounts of 0 and 1 free run; 2 is the smallest bounded move.
    queue_req(CMD_FWD, 4'd3, 16'd0);
    queue_req(CMD_FWD, 4'd7, 16'd1);
    queue_req(CMD_LEDGE, 4'd0, 16'd0);
    queue_req(CMD_REDGE, 4'd0, 16'd0);
    // One centimeter back at the default scale; the last of the queued left-wheel edges ends the move.
    queue_req(CMD_BACK, 4'd2, 16'd16);
    repeat (4) queue_req(CMD_LEDGE, 4'd0, 16'd0);
    // A stopped wheel still sits on its target, so move done repeats.
    queue_req(CMD_LEDGE, 4'd0, 16'd0);
    queue_req(CMD_LEFT, 4'd12, 16'd2);
    queue_req(CMD_REDGE, 4'd0, 16'd0);
    queue_req(CMD_RIGHT, 4'd4, 16'hFFFF);
    queue_req(CMD_TICK, 4'd0, 16'd0);
    queue_req(CMD_UNUSED_LO, 4'd6, 16'd100);
    queue_req(CMD_UNUSED_HI, 4'd9, 16'd100);
    // Zero counts: the target equals the current count.
    queue_req(CMD_BACK, 4'd9, 16'd2);
    queue_req(CMD_REDGE, 4'd0, 16'd0);
    queue_req(CMD_STOP, 4'd0, 16'd0);
    queue_random(60);
    drain();

    set_config(16'hFFFF, 7'd127, 7'd1, 10'd1023);
    queue_random(90);
    drain();

    // A period of zero checks on every tick, like a period of one.
    set_config(16'd1, 7'd1, 7'd0, 10'd0);
    queue_random(90);
    drain();

    set_config(16'd4096, 7'd1, 7'd3, 10'd2);
    queue_random(150);
    drain();

    repeat (3) begin
      set_config(16'($urandom_range(8192, 256)), 7'($urandom_range(4, 1)),
                 7'($urandom_range(10, 1)), 10'($urandom_range(6, 0)));
      queue_random(100);
      drain();
    end

    $display("Checked %0d results from %0d requests over %0d register settings.",
             results_checked, reqs_accepted, settings_used);
    $display("Seen %0d completed moves, %0d stall warnings and %0d count reports.",
             done_events, stall_events, report_events);
    if (mismatch_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
hdl/twm_pkg.sv
hdl/twm_if.sv
hdl/twm_ctrl.sv
hdl/twm_dp.sv
hdl/two_wheel_encoder_move_controller.sv
hdl/twm_checker.sv
tb/sv/two_wheel_encoder_move_controller_test.sv
